>>> rtl/core/palette_ram_color_convert_unit_assert.svh
// assertion macros shared by the palette ram color convert checker
`ifndef PALETTE_RAM_COLOR_CONVERT_UNIT_ASSERT_SVH
`define PALETTE_RAM_COLOR_CONVERT_UNIT_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define PRC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("prc check failed");

// next-cycle implication, sampled on i_clk, off during reset
`define PRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("prc check failed");

`endif

>>> rtl/core/prc_pkg.sv
// types, constants and helper functions for the palette ram color convert unit
`timescale 1ns / 1ps

package prc_pkg;

    // store geometry
    localparam int ADDR_W      = 13;
    localparam int WORD_AW     = 12;
    localparam int WORDS       = 4096;
    localparam int COLOR_W     = 16;
    localparam int DATA_W      = 32;
    localparam int PIX_W       = 16;
    localparam int MULT_W      = 8;
    localparam int CH_W        = 5;
    localparam int PROD_W      = CH_W + MULT_W;

    localparam logic [MULT_W-1:0] SHADOW_RESET = 8'd161;

    // transaction kinds
    typedef enum logic [2:0] {
        K_WR_BYTE = 3'd0,
        K_WR_WORD = 3'd1,
        K_WR_LONG = 3'd2,
        K_RD_BYTE = 3'd3,
        K_RD_WORD = 3'd4,
        K_RD_LONG = 3'd5,
        K_LOOKUP  = 3'd6
    } t_kind;

    // 5-bit color channels
    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } t_rgb;

    // pixel high nibble mod 3 selects the table bank
    localparam logic [1:0] BANK_LUT [0:15] = '{
        2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1,
        2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0
    };

    // palette word to channels: 4 bits each plus a low bit from bits 12..14
    function automatic t_rgb f_convert(input logic [COLOR_W-1:0] w);
        t_rgb c;
        c.r = {w[3:0],  w[12]};
        c.g = {w[7:4],  w[13]};
        c.b = {w[11:8], w[14]};
        return c;
    endfunction

    // red at bit 11, green at bit 6, blue at bit 0
    function automatic logic [COLOR_W-1:0] f_pack(input t_rgb c);
        return {c.r, c.g, 1'b0, c.b};
    endfunction

    // floor(p / 255), exact for p up to 31 * 255
    function automatic logic [CH_W-1:0] f_div255(input logic [PROD_W-1:0] p);
        logic [PROD_W:0] t;
        t = {1'b0, p} + {{(PROD_W-4){1'b0}}, p[PROD_W-1:8]} + {{PROD_W{1'b0}}, 1'b1};
        return t[PROD_W-1:8];
    endfunction

endpackage

>>> rtl/core/prc_ram.sv
// generic single-write, single-read synchronous ram with registered read data
`timescale 1ns / 1ps

module prc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/prc_shade.sv
// shading unit: channel times multiplier, registered, then divide by 255 and pack
`timescale 1ns / 1ps

module prc_shade import prc_pkg::*; (
    input  logic               i_clk,
    input  logic [COLOR_W-1:0] i_word,
    input  logic [MULT_W-1:0]  i_mult,
    output logic [COLOR_W-1:0] o_shaded
);

    t_rgb              w_rgb;
    t_rgb              w_out;
    logic [PROD_W-1:0] r_prod_r;
    logic [PROD_W-1:0] r_prod_g;
    logic [PROD_W-1:0] r_prod_b;

    assign w_rgb = f_convert(i_word);

    // products of each channel with the shadow multiplier
    always_ff @(posedge i_clk) begin
        r_prod_r <= {{MULT_W{1'b0}}, w_rgb.r} * {{CH_W{1'b0}}, i_mult};
        r_prod_g <= {{MULT_W{1'b0}}, w_rgb.g} * {{CH_W{1'b0}}, i_mult};
        r_prod_b <= {{MULT_W{1'b0}}, w_rgb.b} * {{CH_W{1'b0}}, i_mult};
    end

    // scale back by 255 and repack
    always_comb begin
        w_out.r = f_div255(r_prod_r);
        w_out.g = f_div255(r_prod_g);
        w_out.b = f_div255(r_prod_b);
    end

    assign o_shaded = f_pack(w_out);

endmodule

>>> rtl/core/palette_ram_color_convert_unit.sv
// top level: palette byte store with color conversion into shaded table banks
//
//  channel  direction  handshake              payload
//  in       sink       i_valid / o_stall      i_kind i_address i_write_data i_pixel_value
//  out      source     o_valid / i_stall      o_read_data o_next_address o_color_out
//  cfg      sink       i_cfg_wr_en            i_cfg_wr_data (shadow multiplier)
//
// one transaction at a time; each touches one to three 16-bit palette words
// per word the sequencer steps through S_RD for the registered ram read, then S_MRG to
// merge or collect the bytes, and on writes S_SHD for the registered shading product;
// lookups go through S_RD and S_LKD, and an unused kind goes straight to S_DONE
// after reset both rams are cleared while o_stall stays high
// a waiting result sits in the output register, so the next transaction can already run
`timescale 1ns / 1ps

module palette_ram_color_convert_unit import prc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_kind,
    input  logic [ADDR_W-1:0]  i_address,
    input  logic [DATA_W-1:0]  i_write_data,
    input  logic [PIX_W-1:0]   i_pixel_value,
    // output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [DATA_W-1:0]  o_read_data,
    output logic [ADDR_W-1:0]  o_next_address,
    output logic [COLOR_W-1:0] o_color_out,
    // configuration
    input  logic               i_cfg_wr_en,
    input  logic [MULT_W-1:0]  i_cfg_wr_data
);

    typedef enum logic [6:0] {
        S_CLR  = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_RD   = 7'b0000100,
        S_MRG  = 7'b0001000,
        S_SHD  = 7'b0010000,
        S_LKD  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    // control registers
    t_state              r_state,     n_state;
    logic [WORD_AW-1:0]  r_clr_cnt,   n_clr_cnt;
    logic                r_out_valid, n_out_valid;
    logic [MULT_W-1:0]   r_shadow;

    // payload registers
    t_kind               r_kind,      n_kind;
    logic [ADDR_W-1:0]   r_addr,      n_addr;
    logic [DATA_W-1:0]   r_data,      n_data;
    logic [2:0]          r_size,      n_size;
    logic [1:0]          r_last,      n_last;
    logic [1:0]          r_j,         n_j;
    logic [WORD_AW-1:0]  r_word_idx,  n_word_idx;
    logic [1:0]          r_bank,      n_bank;
    logic [DATA_W-1:0]   r_rd_acc,    n_rd_acc;
    logic [COLOR_W-1:0]  r_col,       n_col;
    logic [DATA_W-1:0]   r_out_rd,    n_out_rd;
    logic [ADDR_W-1:0]   r_out_na,    n_out_na;
    logic [COLOR_W-1:0]  r_out_col,   n_out_col;

    // datapath
    logic                w_is_write;
    logic [COLOR_W-1:0]  w_pal_rdata;
    logic [COLOR_W-1:0]  w_shd_rdata;
    logic [COLOR_W-1:0]  w_merged;
    logic [COLOR_W-1:0]  w_shaded;
    logic                w_pal_we;
    logic                w_shd_we;
    logic [WORD_AW-1:0]  w_waddr;
    logic [COLOR_W-1:0]  w_pal_wdata;
    logic [COLOR_W-1:0]  w_shd_wdata;
    logic [2:0]          w_a0;
    logic [2:0]          w_t_hi;
    logic [2:0]          w_t_lo;
    logic [2:0]          w_rel_hi;
    logic [2:0]          w_rel_lo;
    logic                w_ok_hi;
    logic                w_ok_lo;
    logic [2:0]          w_bidx_hi;
    logic [2:0]          w_bidx_lo;
    logic [7:0]          w_wbyte_hi;
    logic [7:0]          w_wbyte_lo;
    logic [2:0]          w_in_size;
    logic [1:0]          w_in_last;
    logic                w_out_free;

    // kind decode
    assign w_is_write = (r_kind inside {K_WR_BYTE, K_WR_WORD, K_WR_LONG});

    always_comb begin
        case (t_kind'(i_kind))
            K_WR_BYTE, K_RD_BYTE: w_in_size = 3'd1;
            K_WR_WORD, K_RD_WORD: w_in_size = 3'd2;
            K_WR_LONG, K_RD_LONG: w_in_size = 3'd4;
            default:              w_in_size = 3'd0;
        endcase
    end

    // index of the last palette word a transaction touches
    always_comb begin
        case (t_kind'(i_kind))
            K_WR_WORD, K_RD_WORD: w_in_last = {1'b0, i_address[0]};
            K_WR_LONG, K_RD_LONG: w_in_last = i_address[0] ? 2'd2 : 2'd1;
            default:              w_in_last = 2'd0;
        endcase
    end

    // byte position of each half of the current word within the access
    assign w_a0      = {2'b00, r_addr[0]};
    assign w_t_hi    = {r_j, 1'b0};
    assign w_t_lo    = {r_j, 1'b1};
    assign w_rel_hi  = w_t_hi - w_a0;
    assign w_rel_lo  = w_t_lo - w_a0;
    assign w_ok_hi   = (w_t_hi >= w_a0) && (w_rel_hi < r_size);
    assign w_ok_lo   = (w_t_lo >= w_a0) && (w_rel_lo < r_size);
    assign w_bidx_hi = r_size - 3'd1 - w_rel_hi;
    assign w_bidx_lo = r_size - 3'd1 - w_rel_lo;
    assign w_wbyte_hi = r_data[{w_bidx_hi[1:0], 3'b000} +: 8];
    assign w_wbyte_lo = r_data[{w_bidx_lo[1:0], 3'b000} +: 8];

    // big-endian merge: even byte address is the high half
    assign w_merged = {w_ok_hi ? w_wbyte_hi : w_pal_rdata[15:8],
                       w_ok_lo ? w_wbyte_lo : w_pal_rdata[7:0]};

    // ram write ports: clearing pass or read-modify-write
    assign w_pal_we    = (r_state == S_CLR) || ((r_state == S_MRG) && w_is_write);
    assign w_shd_we    = (r_state == S_CLR) || (r_state == S_SHD);
    assign w_waddr     = (r_state == S_CLR) ? r_clr_cnt : r_word_idx;
    assign w_pal_wdata = (r_state == S_CLR) ? '0 : w_merged;
    assign w_shd_wdata = (r_state == S_CLR) ? '0 : w_shaded;

    prc_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (WORDS)
    ) u_pal_ram (
        .i_clk   (i_clk),
        .i_we    (w_pal_we),
        .i_waddr (w_waddr),
        .i_wdata (w_pal_wdata),
        .i_raddr (r_word_idx),
        .o_rdata (w_pal_rdata)
    );

    // banks one and two are identical, so one shaded ram serves both
    prc_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (WORDS)
    ) u_shd_ram (
        .i_clk   (i_clk),
        .i_we    (w_shd_we),
        .i_waddr (w_waddr),
        .i_wdata (w_shd_wdata),
        .i_raddr (r_word_idx),
        .o_rdata (w_shd_rdata)
    );

    prc_shade u_shade (
        .i_clk    (i_clk),
        .i_word   (w_merged),
        .i_mult   (r_shadow),
        .o_shaded (w_shaded)
    );

    assign w_out_free = !r_out_valid || !i_stall;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_out_valid = r_out_valid;
        n_kind      = r_kind;
        n_addr      = r_addr;
        n_data      = r_data;
        n_size      = r_size;
        n_last      = r_last;
        n_j         = r_j;
        n_word_idx  = r_word_idx;
        n_bank      = r_bank;
        n_rd_acc    = r_rd_acc;
        n_col       = r_col;
        n_out_rd    = r_out_rd;
        n_out_na    = r_out_na;
        n_out_col   = r_out_col;

        // output register drains when taken
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (&r_clr_cnt) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_kind     = t_kind'(i_kind);
                    n_addr     = i_address;
                    n_data     = i_write_data;
                    n_size     = w_in_size;
                    n_last     = w_in_last;
                    n_j        = 2'd0;
                    n_rd_acc   = '0;
                    n_col      = '0;
                    n_bank     = BANK_LUT[i_pixel_value[PIX_W-1:WORD_AW]];
                    if (t_kind'(i_kind) == K_LOOKUP) begin
                        n_word_idx = i_pixel_value[WORD_AW-1:0];
                        n_state    = S_RD;
                    end else if (w_in_size == 3'd0) begin
                        n_state    = S_DONE;
                    end else begin
                        n_word_idx = i_address[ADDR_W-1:1];
                        n_state    = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = (r_kind == K_LOOKUP) ? S_LKD : S_MRG;
            end
            S_MRG: begin
                if (w_is_write) begin
                    n_state = S_SHD;
                end else begin
                    // collect bytes in address order
                    if (w_ok_hi && w_ok_lo) begin
                        n_rd_acc = {r_rd_acc[15:0], w_pal_rdata};
                    end else if (w_ok_hi) begin
                        n_rd_acc = {r_rd_acc[23:0], w_pal_rdata[15:8]};
                    end else if (w_ok_lo) begin
                        n_rd_acc = {r_rd_acc[23:0], w_pal_rdata[7:0]};
                    end
                    if (r_j == r_last) begin
                        n_state = S_DONE;
                    end else begin
                        n_j        = r_j + 2'd1;
                        n_word_idx = r_word_idx + 1'b1;
                        n_state    = S_RD;
                    end
                end
            end
            S_SHD: begin
                if (r_j == r_last) begin
                    n_state = S_DONE;
                end else begin
                    n_j        = r_j + 2'd1;
                    n_word_idx = r_word_idx + 1'b1;
                    n_state    = S_RD;
                end
            end
            S_LKD: begin
                n_col   = (r_bank == 2'd0) ? f_pack(f_convert(w_pal_rdata)) : w_shd_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_rd    = r_rd_acc;
                    n_out_na    = r_addr + {{(ADDR_W-3){1'b0}}, r_size};
                    n_out_col   = r_col;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // shadow multiplier register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shadow <= SHADOW_RESET;
        end else if (i_cfg_wr_en) begin
            r_shadow <= i_cfg_wr_data;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_addr     <= n_addr;
        r_data     <= n_data;
        r_size     <= n_size;
        r_last     <= n_last;
        r_j        <= n_j;
        r_word_idx <= n_word_idx;
        r_bank     <= n_bank;
        r_rd_acc   <= n_rd_acc;
        r_col      <= n_col;
        r_out_rd   <= n_out_rd;
        r_out_na   <= n_out_na;
        r_out_col  <= n_out_col;
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_read_data    = r_out_rd;
    assign o_next_address = r_out_na;
    assign o_color_out    = r_out_col;

endmodule

>>> rtl/core/prc_checker.sv
// port-level checker for the palette ram color convert unit, bound to the top level
`timescale 1ns / 1ps
`include "palette_ram_color_convert_unit_assert.svh"

module prc_checker import prc_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic [DATA_W-1:0]  o_read_data,
    input logic [ADDR_W-1:0]  o_next_address,
    input logic [COLOR_W-1:0] o_color_out
);

    logic [DATA_W+ADDR_W+COLOR_W-1:0] w_out_word;

    // whole result payload as one word
    assign w_out_word = {o_read_data, o_next_address, o_color_out};

    // a stalled result stays offered
    `PRC_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid)

    // a stalled result keeps its payload
    `PRC_ASSERT_NEXT(a_out_stable, o_valid && i_stall, $stable(w_out_word))

    // a transaction carries read data or a color, never both
    `PRC_ASSERT_NOW(a_one_result, o_valid, (o_read_data == 32'd0) || (o_color_out == 16'd0))

    // one transaction in flight: accepting one closes the input
    `PRC_ASSERT_NEXT(a_one_at_a_time, i_valid && !o_stall, o_stall)

endmodule

bind palette_ram_color_convert_unit prc_checker u_prc_checker (.*);

>>> test/tb.sv
// self-checking testbench for the palette ram color convert unit
`timescale 1ns / 1ps

module tb;
    import prc_pkg::*;

    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          SETTLE_CYCLES  = 24;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          PHASE_ITEMS    = 150;
    localparam logic [2:0]  KIND_UNUSED    = 3'd7;
    localparam int          TABLE_ENTRIES  = 3 * WORDS;

    // one bus reply as the block should return it
    typedef struct {
        logic [DATA_W-1:0]  read_data;
        logic [ADDR_W-1:0]  next_address;
        logic [COLOR_W-1:0] color_out;
    } t_bus_reply;

    // mirror of the palette bytes and the three color table banks
    class palette_mirror;
        logic [7:0]         pal_bytes [0:(1 << ADDR_W) - 1];
        logic [COLOR_W-1:0] color_tab [0:TABLE_ENTRIES - 1];
        logic [MULT_W-1:0]  shadow;
        t_bus_reply         replies [$];
        int unsigned        mismatches;

        function new();
            foreach (pal_bytes[i]) pal_bytes[i] = 8'h00;
            foreach (color_tab[i]) color_tab[i] = '0;
            shadow     = SHADOW_RESET;
            mismatches = 0;
        endfunction

        function void set_shadow(input logic [MULT_W-1:0] m);
            shadow = m;
        endfunction

        // 5-bit channels into red 15:11, green 10:6, blue 4:0
        function logic [COLOR_W-1:0] pack_color(input int unsigned r, g, b);
            int unsigned v;
            v = (r << 11) | (g << 6) | b;
            return v[COLOR_W-1:0];
        endfunction

        // rebuild all three banks for the word holding this byte
        function void refresh_word(input logic [ADDR_W-1:0] byte_off);
            logic [ADDR_W-1:0]  base;
            logic [15:0]        w;
            int unsigned        r, g, b, idx;
            base = {byte_off[ADDR_W-1:1], 1'b0};
            w    = {pal_bytes[base], pal_bytes[base + 1]};
            r    = ((w & 16'h000f) << 1) | ((w >> 12) & 1);
            g    = ((w & 16'h00f0) >> 3) | ((w >> 13) & 1);
            b    = ((w & 16'h0f00) >> 7) | ((w >> 14) & 1);
            idx  = (base >> 1) % WORDS;
            color_tab[idx]             = pack_color(r, g, b);
            color_tab[idx + WORDS]     = pack_color(r * shadow / 255, g * shadow / 255,
                                                    b * shadow / 255);
            color_tab[idx + 2 * WORDS] = color_tab[idx + WORDS];
        endfunction

        // apply one accepted transaction and queue its reply
        function void note_access(input logic [2:0] kind, input logic [ADDR_W-1:0] addr,
                                  input logic [DATA_W-1:0] data,
                                  input logic [PIX_W-1:0] pix);
            t_bus_reply        rep;
            int unsigned       size, i;
            logic [ADDR_W-1:0] a;
            rep.read_data = '0;
            rep.color_out = '0;
            size = 0;
            case (kind)
                K_WR_BYTE, K_RD_BYTE: size = 1;
                K_WR_WORD, K_RD_WORD: size = 2;
                K_WR_LONG, K_RD_LONG: size = 4;
                default:              size = 0;
            endcase
            case (kind)
                K_WR_BYTE, K_WR_WORD, K_WR_LONG: begin
                    for (i = 0; i < size; i++) begin
                        a = addr + ADDR_W'(i);
                        pal_bytes[a] = 8'(data >> (8 * (size - 1 - i)));
                    end
                    for (i = 0; i < size; i++) begin
                        refresh_word(addr + ADDR_W'(i));
                    end
                end
                K_RD_BYTE, K_RD_WORD, K_RD_LONG: begin
                    for (i = 0; i < size; i++) begin
                        a = addr + ADDR_W'(i);
                        rep.read_data = (rep.read_data << 8) | DATA_W'(pal_bytes[a]);
                    end
                end
                K_LOOKUP: rep.color_out = color_tab[pix % TABLE_ENTRIES];
                default: ;
            endcase
            rep.next_address = addr + ADDR_W'(size);
            replies.push_back(rep);
        endfunction

        // compare one accepted result against the oldest queued reply
        function void check_result(input logic [DATA_W-1:0] rd,
                                   input logic [ADDR_W-1:0] na,
                                   input logic [COLOR_W-1:0] col);
            t_bus_reply rep;
            if (replies.size() == 0) begin
                $display("%0t: unexpected result rd=%h next=%h color=%h", $time, rd, na, col);
                mismatches++;
            end else begin
                rep = replies.pop_front();
                if (rd !== rep.read_data) begin
                    $display("%0t: read_data expected %h actual %h", $time, rep.read_data, rd);
                    mismatches++;
                end
                if (na !== rep.next_address) begin
                    $display("%0t: next_address expected %h actual %h", $time,
                             rep.next_address, na);
                    mismatches++;
                end
                if (col !== rep.color_out) begin
                    $display("%0t: color_out expected %h actual %h", $time, rep.color_out, col);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [2:0]         i_kind;
    logic [ADDR_W-1:0]  i_address;
    logic [DATA_W-1:0]  i_write_data;
    logic [PIX_W-1:0]   i_pixel_value;
    logic               o_valid;
    logic               i_stall;
    logic [DATA_W-1:0]  o_read_data;
    logic [ADDR_W-1:0]  o_next_address;
    logic [COLOR_W-1:0] o_color_out;
    logic               i_cfg_wr_en;
    logic [MULT_W-1:0]  i_cfg_wr_data;

    palette_mirror mirror;
    int unsigned   send_pct     = 0;
    int unsigned   stall_pct    = 0;
    bit            hold_request = 1'b0;
    int unsigned   hold_left    = 0;
    int unsigned   quiet_cycles = 0;

    palette_ram_color_convert_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_address      (i_address),
        .i_write_data   (i_write_data),
        .i_pixel_value  (i_pixel_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_read_data    (o_read_data),
        .o_next_address (o_next_address),
        .o_color_out    (o_color_out),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // result side: check accepted results, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            mirror.check_result(o_read_data, o_next_address, o_color_out);
        end
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one transaction, with random idle cycles ahead of it
    task automatic send_item(input logic [2:0] kind, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data, input logic [PIX_W-1:0] pix);
        while (send_pct != 0 && $urandom_range(99) < send_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_kind        <= kind;
        i_address     <= addr;
        i_write_data  <= data;
        i_pixel_value <= pix;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        mirror.note_access(kind, addr, data, pix);
    endtask

    // random transaction, mostly in a small window so reads and lookups hit written words
    task automatic send_random_item();
        logic [2:0]        kind;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pix;
        int unsigned       pick;
        pick = $urandom_range(99);
        if (pick < 40)      kind = 3'($urandom_range(2));
        else if (pick < 70) kind = 3'(3 + $urandom_range(2));
        else if (pick < 97) kind = K_LOOKUP;
        else                kind = KIND_UNUSED;
        case ($urandom_range(9))
            0:       addr = ADDR_W'($urandom_range(8191));
            1:       addr = ADDR_W'(8191 - $urandom_range(7));
            default: addr = ADDR_W'($urandom_range(63));
        endcase
        case ($urandom_range(3))
            0:       pix = PIX_W'($urandom);
            1:       pix = PIX_W'($urandom_range(2) * WORDS + WORDS - 1 - $urandom_range(4));
            default: pix = PIX_W'($urandom_range(2) * WORDS + $urandom_range(33));
        endcase
        send_item(kind, addr, $urandom, pix);
    endtask

    // stop offering, wait for every queued reply, then let the block settle
    task automatic drain_and_settle();
        i_valid <= 1'b0;
        while (mirror.replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_shadow(input logic [MULT_W-1:0] m);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= m;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        mirror.set_shadow(m);
    endtask

    // full-scale word, then the same entry from all three banks
    task automatic shade_probe();
        send_item(K_WR_WORD, 13'h0020, 32'h5a5a7fff, 16'h0000);
        send_item(K_LOOKUP, 13'h0000, 32'h0000_0000, 16'(16));
        send_item(K_LOOKUP, 13'h0000, 32'h0000_0000, 16'(16 + WORDS));
        send_item(K_LOOKUP, 13'h0000, 32'h0000_0000, 16'(16 + 2 * WORDS));
    endtask

    // one random phase at a given shadow setting and idle mix
    task automatic run_phase(input logic [MULT_W-1:0] m, input int unsigned s_pct,
                             input int unsigned r_pct, input bit pressure);
        int unsigned n;
        drain_and_settle();
        write_shadow(m);
        send_pct  = s_pct;
        stall_pct = r_pct;
        for (n = 0; n < PHASE_ITEMS; n++) begin
            if (pressure && n == 20) hold_request = 1'b1;
            send_random_item();
        end
    endtask

    // main sequence
    initial begin
        mirror        = new();
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_stall       = 1'b0;
        i_kind        = K_WR_BYTE;
        i_address     = '0;
        i_write_data  = '0;
        i_pixel_value = '0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // clearing pass after reset
        while (o_stall) @(posedge i_clk);

        // directed: cleared store, extremes, wrap, odd alignment, unused kind
        send_item(K_RD_LONG, 13'h0000, 32'h0000_0000, 16'h0000);
        send_item(K_LOOKUP,  13'h0000, 32'h0000_0000, 16'hffff);
        send_item(K_WR_WORD, 13'h0000, 32'ha5a5_7fff, 16'h0000);
        send_item(K_LOOKUP,  13'h0000, 32'h0000_0000, 16'(0));
        send_item(K_LOOKUP,  13'h0000, 32'h0000_0000, 16'(WORDS));
        send_item(K_LOOKUP,  13'h0000, 32'h0000_0000, 16'(2 * WORDS));
        send_item(K_WR_WORD, 13'h0002, 32'h0000_8000, 16'h0001);
        send_item(K_WR_LONG, 13'h1ffe, 32'hffff_ffff, 16'h0000);
        send_item(K_RD_LONG, 13'h1ffe, 32'h0000_0000, 16'h0000);
        send_item(K_RD_WORD, 13'h1fff, 32'h0000_0000, 16'h0000);
        send_item(K_LOOKUP,  13'h0000, 32'h0000_0000, 16'(WORDS - 1));
        send_item(K_LOOKUP,  13'h0000, 32'h0000_0000, 16'(0));
        send_item(K_WR_WORD, 13'h0003, 32'h0000_1234, 16'h0000);
        send_item(K_RD_LONG, 13'h0002, 32'h0000_0000, 16'h0000);
        send_item(K_LOOKUP,  13'h0000, 32'h0000_0000, 16'(WORDS + 1));
        send_item(K_LOOKUP,  13'h0000, 32'h0000_0000, 16'(2 * WORDS + 2));
        send_item(K_WR_BYTE, 13'h1fff, 32'hdead_beab, 16'h0000);
        send_item(K_RD_BYTE, 13'h1fff, 32'h0000_0000, 16'h0000);
        send_item(KIND_UNUSED, 13'h1fff, 32'hffff_ffff, 16'hffff);
        send_item(K_LOOKUP,  13'h0000, 32'h0000_0000, 16'(TABLE_ENTRIES - 1));
        send_item(K_LOOKUP,  13'h0000, 32'h0000_0000, 16'(TABLE_ENTRIES));
        drain_and_settle();
        write_shadow(8'd0);
        shade_probe();
        drain_and_settle();
        write_shadow(8'd255);
        shade_probe();

        // random phases over shadow settings and idle mixes
        run_phase(8'd255,                0,  0,  1'b1);
        run_phase(8'd0,                  87, 0,  1'b0);
        run_phase(8'($urandom_range(255)), 0,  87, 1'b0);
        run_phase(8'd1,                  26, 26, 1'b0);
        run_phase(8'd254,                0,  0,  1'b0);
        run_phase(8'($urandom_range(255)), 87, 0,  1'b0);
        run_phase(8'd128,                0,  87, 1'b0);
        run_phase(8'd161,                26, 26, 1'b0);

        drain_and_settle();
        if (mirror.replies.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, mirror.replies.size());
        end
        if (mirror.mismatches == 0 && mirror.replies.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/prc_pkg.sv
rtl/core/prc_ram.sv
rtl/core/prc_shade.sv
rtl/core/palette_ram_color_convert_unit.sv
rtl/core/prc_checker.sv
test/tb.sv
